/* sv/double_ended_queue_defines.svh */
// Assertion macros shared by the double-ended queue checkers.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/deq_pkg.sv */
// Types and codes shared by the double-ended queue modules.
package deq_pkg;

	localparam int unsigned WordW = 32;

	// Request codes carried on the action port.
	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	// Result codes carried on the status port.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

endpackage

/* sv/deq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             re,
	input  logic [AddrW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/double_ended_queue.sv */
// Top level of the double-ended queue of signed 32-bit words.
//
// Requests enter on the command channel: a transfer happens at a rising edge
// where start is high and busy is low. action selects push front, push back,
// pop front or pop back; push_value is the word to insert on a push.
// Every request yields exactly one result, shown for one cycle with done high:
// status, pop_value (zero unless a pop succeeded), is_empty and entry_count,
// all describing the queue after the request.
// done is raised in the cycle after the request transfer. The words live in a
// single RAM with one write and one registered read port; each request uses
// at most one of those ports, so a new request is taken every cycle and busy
// stays low. A pop reads the RAM in the request cycle and its data arrives
// with done; a push written in one cycle is visible to a pop in the next.
// A pop from an empty queue or a push into a full queue reports an error and
// leaves the queue unchanged.
// Reset clears the front pointer and the entry count; RAM contents are not
// cleared, since only written entries are ever read. The receiver cannot
// stall: each result must be taken in the cycle done is high.
module double_ended_queue #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned IdxW = $clog2(DEPTH),
	localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic signed [deq_pkg::WordW-1:0] push_value,
	output logic                       done,
	output logic [1:0]                 status,
	output logic signed [deq_pkg::WordW-1:0] pop_value,
	output logic                       is_empty,
	output logic [CntW-1:0]            entry_count
);

	import deq_pkg::*;

	localparam logic [CntW:0]   DepthS   = (CntW + 1)'(DEPTH);
	localparam logic [CntW-1:0] DepthC   = CntW'(DEPTH);
	localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);

	logic [IdxW-1:0] front_q;
	logic [CntW-1:0] count_q;
	logic            done_q;
	logic            pop_ok_q;
	status_t         status_q;
	logic [CntW-1:0] count_out_q;

	logic            accept;
	action_t         act;
	logic            is_full;
	logic            is_none;
	logic [IdxW-1:0] front_dec;
	logic [IdxW-1:0] front_inc;
	logic [CntW:0]   back_sum;
	logic [CntW:0]   last_sum;
	logic [IdxW-1:0] back_slot;
	logic [IdxW-1:0] last_slot;
	logic [IdxW-1:0] front_nxt;
	logic [CntW-1:0] count_nxt;
	status_t         status_nxt;
	logic            ram_we;
	logic [IdxW-1:0] ram_wa;
	logic            ram_re;
	logic [IdxW-1:0] ram_ra;
	logic [WordW-1:0] ram_rd;

	// Every request completes in at most one RAM access, so requests are never held off.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign act    = action_t'(action);

	// Ring slot arithmetic around the front pointer.
	always_comb begin
		is_full   = (count_q == DepthC);
		is_none   = (count_q == '0);
		front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;
		front_inc = (front_q == LastIdx) ? '0 : front_q + 1'b1;
		back_sum  = (CntW + 1)'(front_q) + (CntW + 1)'(count_q);
		last_sum  = back_sum - 1'b1;
		back_slot = (back_sum >= DepthS) ? IdxW'(back_sum - DepthS) : IdxW'(back_sum);
		last_slot = (last_sum >= DepthS) ? IdxW'(last_sum - DepthS) : IdxW'(last_sum);
	end

	// Decode the request into RAM accesses and the next pointer and count.
	always_comb begin
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		ram_we     = 1'b0;
		ram_wa     = back_slot;
		ram_re     = 1'b0;
		ram_ra     = front_q;
		case (act)
			ACT_PUSH_FRONT: begin
				if (is_full) begin
					status_nxt = ST_PUSH_FULL;
				end else begin
					ram_we    = accept;
					ram_wa    = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = ST_PUSH_FULL;
				end else begin
					ram_we    = accept;
					ram_wa    = back_slot;
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (is_none) begin
					status_nxt = ST_POP_EMPTY;
				end else begin
					ram_re    = accept;
					ram_ra    = front_q;
					front_nxt = front_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (is_none) begin
					status_nxt = ST_POP_EMPTY;
				end else begin
					ram_re    = accept;
					ram_ra    = last_slot;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// Word storage.
	deq_ram #(
		.WIDTH(WordW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wa),
		.wr_data(push_value),
		.re     (ram_re),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	// Queue pointers and result control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			pop_ok_q <= 1'b0;
		end else begin
			done_q   <= accept;
			pop_ok_q <= ram_re;
			if (accept) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end
		end
	end

	// Result payload captured with the request transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			count_out_q <= count_nxt;
		end
	end

	// Result ports; popped data comes straight from the RAM read register.
	assign done        = done_q;
	assign status      = status_q;
	assign pop_value   = pop_ok_q ? ram_rd : '0;
	assign entry_count = count_out_q;
	assign is_empty    = (count_out_q == '0);

endmodule

/* sv/deq_checker.sv */
// Port-level checker for the double-ended queue, bound to the top level.
`include "double_ended_queue_defines.svh"

module deq_checker #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic [1:0]                       action,
	input logic                             done,
	input logic [1:0]                       status,
	input logic signed [deq_pkg::WordW-1:0] pop_value,
	input logic                             is_empty,
	input logic [CntW-1:0]                  entry_count
);

	import deq_pkg::*;

	localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

	// Each request transfer yields its result in the next cycle.
	`DEQ_ASSERT_NEXT(a_one_result, clk, arst_n, start && !busy, done, "missing result")

	// A result only appears in the cycle after a request transfer.
	`DEQ_ASSERT_NOW(a_no_extra, clk, arst_n, done, $past(start && !busy), "unrequested result")

	// Failed requests and pushes return a zero word.
	`DEQ_ASSERT_NOW(a_zero_word, clk, arst_n, done && (status != ST_OK || $past(action) == ACT_PUSH_FRONT || $past(action) == ACT_PUSH_BACK), pop_value == '0, "nonzero word without a pop")

	// The empty flag agrees with the count, which never exceeds the depth.
	`DEQ_ASSERT_NOW(a_count, clk, arst_n, done, (is_empty == (entry_count == '0)) && (entry_count <= DepthC), "bad count")

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.action     (action),
	.done       (done),
	.status     (status),
	.pop_value  (pop_value),
	.is_empty   (is_empty),
	.entry_count(entry_count)
);
